// File: hdl/ect_pkg.sv
// ----------------------------------------------------------------------------
// ect_pkg
// Shared types, constants and calendar helpers for the epoch to calendar
// converter.
// ----------------------------------------------------------------------------
package ect_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_READY = 2'd1,
    ST_RANGE     = 2'd2
  } status_t;

  // Valid window: 2000-01-01 00:00:00 up to, not including, 2100-01-01
  localparam logic [31:0] FIRST_SEC = 32'd946684800;
  localparam logic [31:0] END_SEC   = 32'd4102444800;

  // Day split: seconds = 128 * 675 per day, quotient by reciprocal 2^32/675
  localparam int          DAY_LO_BITS = 7;
  localparam logic [9:0]  DAY_UNITS   = 10'd675;
  localparam logic [22:0] DAY_RECIP   = 23'd6362914;

  // Time of day: x/60 as (x * 139811) >> 23 for 17-bit x,
  // and (x * 2185) >> 17 for 11-bit x
  localparam logic [5:0]  SEC_PER_MIN = 6'd60;
  localparam logic [17:0] MIN_RECIP   = 18'd139811;
  localparam logic [11:0] HR_RECIP    = 12'd2185;

  // Weekday: 2000-01-01 was a Saturday, (days + 5) mod 7 + 1 gives Monday 1
  localparam logic [2:0]  WEEK_BIAS  = 3'd5;
  localparam logic [2:0]  WEEK_DAYS  = 3'd7;
  localparam logic [16:0] WEEK_RECIP = 17'd74899;

  // Leap cycle of four years, first year leap; x/1461 as (x * 45934) >> 26
  localparam logic [10:0] CYCLE_DAYS  = 11'd1461;
  localparam logic [15:0] CYCLE_RECIP = 16'd45934;
  localparam logic [8:0]  LEAP_DAYS   = 9'd366;
  localparam logic [8:0]  YEAR_DAYS   = 9'd365;

  // First day of year of each month, months counted from 0
  function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
    logic [8:0] base;
    case (idx)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    // February 29 pushes every later month by one day
    if (leap && idx >= 4'd2) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

  // Month from day of year: count month starts that are not beyond it
  function automatic logic [3:0] month_index(input logic [8:0] doy, input logic leap);
    logic [3:0] cnt;
    cnt = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (doy >= month_start(4'(m), leap)) begin
        cnt = cnt + 4'd1;
      end
    end
    return cnt;
  endfunction

endpackage

// File: hdl/ect_day_split.sv
// ----------------------------------------------------------------------------
// ect_day_split
// Splits seconds since 2000-01-01 into whole days and seconds of day over
// four register stages (offset, reciprocal multiply, back multiply, fixup).
// ----------------------------------------------------------------------------
module ect_day_split (
  input  logic        clk,
  input  logic [3:0]  stage_en,
  input  logic [31:0] epoch_seconds,
  output logic [15:0] days,
  output logic [16:0] secs
);

  logic [31:0] rel;
  logic [24:0] x1_r, x2_r;
  logic [6:0]  lo1_r, lo2_r, lo3_r, lo4_r;
  logic [47:0] prod;
  logic [15:0] q2_r, q3_r, days_r;
  logic [25:0] qd, diff;
  logic [10:0] r3_r, rr;
  logic        fix;
  logic [9:0]  rem4_r;

  // Stage 1: rebase to 2000, split off the low 7 bits (86400 = 128 * 675)
  assign rel = epoch_seconds - ect_pkg::FIRST_SEC;

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      x1_r  <= rel[31:ect_pkg::DAY_LO_BITS];
      lo1_r <= rel[ect_pkg::DAY_LO_BITS-1:0];
    end
  end

  // Stage 2: quotient estimate, low by at most one
  assign prod = 48'(x1_r) * 48'(ect_pkg::DAY_RECIP);

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      q2_r  <= prod[47:32];
      x2_r  <= x1_r;
      lo2_r <= lo1_r;
    end
  end

  // Stage 3: remainder of the estimate, below twice the divisor
  assign qd   = 26'(q2_r) * 26'(ect_pkg::DAY_UNITS);
  assign diff = 26'(x2_r) - qd;

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      r3_r  <= diff[10:0];
      q3_r  <= q2_r;
      lo3_r <= lo2_r;
    end
  end

  // Stage 4: one correction step
  assign fix = (r3_r >= 11'(ect_pkg::DAY_UNITS));
  assign rr  = fix ? (r3_r - 11'(ect_pkg::DAY_UNITS)) : r3_r;

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      days_r <= q3_r + 16'(fix);
      rem4_r <= rr[9:0];
      lo4_r  <= lo3_r;
    end
  end

  assign days = days_r;
  assign secs = {rem4_r, lo4_r};

endmodule

// File: hdl/ect_tod.sv
// ----------------------------------------------------------------------------
// ect_tod
// Seconds of day to hour, minute and second over three register stages.
// ----------------------------------------------------------------------------
module ect_tod (
  input  logic        clk,
  input  logic [2:0]  stage_en,
  input  logic [16:0] secs,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second
);

  logic [34:0] mp;
  logic [10:0] mins1_r, mins2_r;
  logic [16:0] secs1_r;
  logic [16:0] mm60, sdiff;
  logic [22:0] hp;
  logic [5:0]  sec2_r, sec3_r, min3_r;
  logic [4:0]  hr2_r, hr3_r;
  logic [10:0] hd;

  // Stage 1: minutes of day
  assign mp = 35'(secs) * 35'(ect_pkg::MIN_RECIP);

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      mins1_r <= mp[33:23];
      secs1_r <= secs;
    end
  end

  // Stage 2: second of minute and hour of day
  assign mm60  = 17'(mins1_r) * 17'(ect_pkg::SEC_PER_MIN);
  assign sdiff = secs1_r - mm60;
  assign hp    = 23'(mins1_r) * 23'(ect_pkg::HR_RECIP);

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      sec2_r  <= sdiff[5:0];
      hr2_r   <= hp[21:17];
      mins2_r <= mins1_r;
    end
  end

  // Stage 3: minute of hour
  assign hd = mins2_r - 11'(hr2_r) * 11'(ect_pkg::SEC_PER_MIN);

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      min3_r <= hd[5:0];
      hr3_r  <= hr2_r;
      sec3_r <= sec2_r;
    end
  end

  assign hour   = hr3_r;
  assign minute = min3_r;
  assign second = sec3_r;

endmodule

// File: hdl/ect_date.sv
// ----------------------------------------------------------------------------
// ect_date
// Days since 2000-01-01 to weekday, year, month and day of month: three
// register stages, month lookup after the last one.
// ----------------------------------------------------------------------------
module ect_date (
  input  logic        clk,
  input  logic [2:0]  stage_en,
  input  logic [15:0] days,
  output logic [2:0]  weekday,
  output logic [3:0]  month,
  output logic [4:0]  day_of_month,
  output logic [6:0]  year_offset
);

  logic [16:0] dw;
  logic [33:0] wp;
  logic [31:0] cp;
  logic [13:0] wq1_r;
  logic [16:0] dw1_r;
  logic [4:0]  cyc1_r, cyc2_r;
  logic [15:0] days1_r;
  logic [16:0] wdiff;
  logic [15:0] cdiff;
  logic [2:0]  wd2_r, wd3_r;
  logic [10:0] rem2_r, r1;
  logic [1:0]  yr;
  logic [10:0] doy_w;
  logic [6:0]  year3_r;
  logic [8:0]  doy3_r;
  logic        leap3_r;
  logic [3:0]  mi;
  logic [8:0]  dd;

  // Stage 1: weekday and leap cycle quotients
  assign dw = 17'(days) + 17'(ect_pkg::WEEK_BIAS);
  assign wp = 34'(dw) * 34'(ect_pkg::WEEK_RECIP);
  assign cp = 32'(days) * 32'(ect_pkg::CYCLE_RECIP);

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      wq1_r   <= wp[32:19];
      dw1_r   <= dw;
      cyc1_r  <= cp[30:26];
      days1_r <= days;
    end
  end

  // Stage 2: remainders
  assign wdiff = dw1_r - 17'(wq1_r) * 17'(ect_pkg::WEEK_DAYS);
  assign cdiff = days1_r - 16'(cyc1_r) * 16'(ect_pkg::CYCLE_DAYS);

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      wd2_r  <= wdiff[2:0] + 3'd1;
      rem2_r <= cdiff[10:0];
      cyc2_r <= cyc1_r;
    end
  end

  // Stage 3: year inside the cycle and day of year
  assign r1 = rem2_r - 11'(ect_pkg::LEAP_DAYS);

  always_comb begin
    if (rem2_r < 11'(ect_pkg::LEAP_DAYS)) begin
      yr    = 2'd0;
      doy_w = rem2_r;
    end else if (r1 < 11'(ect_pkg::YEAR_DAYS)) begin
      yr    = 2'd1;
      doy_w = r1;
    end else if (r1 < 11'(2 * ect_pkg::YEAR_DAYS)) begin
      yr    = 2'd2;
      doy_w = r1 - 11'(ect_pkg::YEAR_DAYS);
    end else begin
      yr    = 2'd3;
      doy_w = r1 - 11'(2 * ect_pkg::YEAR_DAYS);
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      year3_r <= {cyc2_r, yr};
      doy3_r  <= doy_w[8:0];
      leap3_r <= (yr == 2'd0);
      wd3_r   <= wd2_r;
    end
  end

  // Month lookup, registered by the output stage
  assign mi = ect_pkg::month_index(doy3_r, leap3_r);
  assign dd = doy3_r - ect_pkg::month_start(mi, leap3_r);

  assign weekday      = wd3_r;
  assign month        = mi + 4'd1;
  assign day_of_month = dd[4:0] + 5'd1;
  assign year_offset  = year3_r;

endmodule

// File: hdl/epoch_to_calendar_gated.sv
// ----------------------------------------------------------------------------
// epoch_to_calendar_gated
// Unix epoch seconds to UTC calendar fields, gated by the clock-ready
// register and the 2000..2099 window.
// ----------------------------------------------------------------------------
// Throughput: 8 register stages, one word per cycle while out_stall is low;
//   each stage holds its word on stall, so bubbles are squeezed out while
//   the output waits.
// Reset (rst_n low, synchronous): pipeline emptied, clock-ready cleared.
// ----------------------------------------------------------------------------
module epoch_to_calendar_gated (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_accepted,
  output logic [1:0]  out_status,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second,
  output logic [2:0]  out_weekday,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day_of_month,
  output logic [6:0]  out_year_offset,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  logic [8:1]  valid_r, valid_nxt;
  logic [8:1]  stage_en;
  logic        clock_up_r;
  ect_pkg::status_t st_in;
  ect_pkg::status_t st_r [1:7];
  logic [15:0] days;
  logic [16:0] secs;
  logic [4:0]  hour;
  logic [5:0]  minute, second;
  logic [2:0]  weekday;
  logic [3:0]  month;
  logic [4:0]  day_of_month;
  logic [6:0]  year_offset;
  logic        ok7;
  logic        out_accepted_r;
  ect_pkg::status_t out_status_r;
  logic [4:0]  out_hour_r;
  logic [5:0]  out_minute_r, out_second_r;
  logic [2:0]  out_weekday_r;
  logic [3:0]  out_month_r;
  logic [4:0]  out_day_of_month_r;
  logic [6:0]  out_year_offset_r;

  // Stage enables: a stage moves when empty or when the next one moves
  always_comb begin
    stage_en[8] = !valid_r[8] || !out_stall;
    for (int k = 7; k >= 1; k--) begin
      stage_en[k] = !valid_r[k] || stage_en[k+1];
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (stage_en[1]) begin
      valid_nxt[1] = in_valid;
    end
    for (int k = 2; k <= 8; k++) begin
      if (stage_en[k]) begin
        valid_nxt[k] = valid_r[k-1];
      end
    end
  end

  assign in_stall  = !stage_en[1];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      clock_up_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (cfg_valid && cfg_ready) begin
        clock_up_r <= cfg_data;
      end
    end
  end

  // Request gating, checked at entry and carried down the pipe
  always_comb begin
    if (!clock_up_r) begin
      st_in = ect_pkg::ST_NOT_READY;
    end else if (in_epoch_seconds < ect_pkg::FIRST_SEC ||
                 in_epoch_seconds >= ect_pkg::END_SEC) begin
      st_in = ect_pkg::ST_RANGE;
    end else begin
      st_in = ect_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      st_r[1] <= st_in;
    end
    for (int k = 2; k <= 7; k++) begin
      if (stage_en[k]) begin
        st_r[k] <= st_r[k-1];
      end
    end
  end

  // Stages 1 to 4: days and seconds of day
  ect_day_split u_day_split (
    .clk           (clk),
    .stage_en      (stage_en[4:1]),
    .epoch_seconds (in_epoch_seconds),
    .days          (days),
    .secs          (secs)
  );

  // Stages 5 to 7: time of day
  ect_tod u_tod (
    .clk      (clk),
    .stage_en (stage_en[7:5]),
    .secs     (secs),
    .hour     (hour),
    .minute   (minute),
    .second   (second)
  );

  // Stages 5 to 7: date
  ect_date u_date (
    .clk          (clk),
    .stage_en     (stage_en[7:5]),
    .days         (days),
    .weekday      (weekday),
    .month        (month),
    .day_of_month (day_of_month),
    .year_offset  (year_offset)
  );

  // Stage 8: output word, fields zeroed on reject
  assign ok7 = (st_r[7] == ect_pkg::ST_OK);

  always_ff @(posedge clk) begin
    if (stage_en[8]) begin
      out_accepted_r     <= ok7;
      out_status_r       <= st_r[7];
      out_hour_r         <= ok7 ? hour : '0;
      out_minute_r       <= ok7 ? minute : '0;
      out_second_r       <= ok7 ? second : '0;
      out_weekday_r      <= ok7 ? weekday : '0;
      out_month_r        <= ok7 ? month : '0;
      out_day_of_month_r <= ok7 ? day_of_month : '0;
      out_year_offset_r  <= ok7 ? year_offset : '0;
    end
  end

  assign out_valid        = valid_r[8];
  assign out_accepted     = out_accepted_r;
  assign out_status       = out_status_r;
  assign out_hour         = out_hour_r;
  assign out_minute       = out_minute_r;
  assign out_second       = out_second_r;
  assign out_weekday      = out_weekday_r;
  assign out_month        = out_month_r;
  assign out_day_of_month = out_day_of_month_r;
  assign out_year_offset  = out_year_offset_r;

`ifndef ASSERT_OFF
  // Input is held off only when every stage is full and the output waits
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (valid_r == '1 && out_stall))
    else $error("input stalled with room in the pipe");

  // A full stage that cannot move keeps its word
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r[4] && !stage_en[4]) |=> valid_r[4])
    else $error("stalled stage lost its word");

  // Accepted flag and status agree
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_accepted == (out_status == ect_pkg::ST_OK)))
    else $error("accepted flag and status disagree");

  // A rejected word carries zero calendar fields
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_accepted) |->
      (out_hour == '0 && out_minute == '0 && out_second == '0 &&
       out_weekday == '0 && out_month == '0 && out_day_of_month == '0 &&
       out_year_offset == '0))
    else $error("rejected word has nonzero fields");

  // An accepted word has calendar fields in range
  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_accepted) |->
      (out_hour < 5'd24 && out_minute < 6'd60 && out_second < 6'd60 &&
       out_weekday != 3'd0 && out_month != 4'd0 && out_month < 4'd13 &&
       out_day_of_month != 5'd0 && out_year_offset < 7'd100))
    else $error("calendar field out of range");
`endif

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the epoch to calendar converter. Words are pushed
// through the valid/stall channels with random gaps and stalls, and each
// result is checked against a calendar predictor, under both settings of
// the clock-ready register.
// ----------------------------------------------------------------------------

// One result word, fields at port widths
typedef struct packed {
  logic             accepted;
  ect_pkg::status_t status;
  logic [4:0]       hour;
  logic [5:0]       minute;
  logic [5:0]       second;
  logic [2:0]       weekday;
  logic [3:0]       month;
  logic [4:0]       day_of_month;
  logic [6:0]       year_offset;
} cal_word_t;

typedef struct {
  logic [31:0] epoch;
  cal_word_t   cal;
} cal_due_t;

class calendar_scoreboard;
  cal_due_t    cal_due[$];
  bit          rtc_up;
  int unsigned n_checked;
  int unsigned n_converted;
  int unsigned n_not_ready;
  int unsigned n_range;
  int unsigned n_errors;

  // Calendar fields for one epoch value under the current register
  function cal_word_t calendar_of(logic [31:0] t);
    cal_word_t   r;
    int unsigned days;
    int unsigned tod;
    int unsigned doy;
    int unsigned yr;
    int unsigned mon;
    int unsigned ylen;
    int unsigned mlen;
    r = '0;
    if (!rtc_up) begin
      r.status = ect_pkg::ST_NOT_READY;
    end else if (t < ect_pkg::FIRST_SEC || t >= ect_pkg::END_SEC) begin
      r.status = ect_pkg::ST_RANGE;
    end else begin
      days = t / 32'd86400;
      tod  = t % 32'd86400;
      // walk whole years from 2000; every fourth year from 2000 is leap
      doy  = days - 10957;
      yr   = 0;
      ylen = 366;
      while (doy >= ylen) begin
        doy  = doy - ylen;
        yr   = yr + 1;
        ylen = (yr % 4 == 0) ? 366 : 365;
      end
      // then whole months
      mon  = 0;
      mlen = 31;
      while (doy >= mlen) begin
        doy  = doy - mlen;
        mon  = mon + 1;
        if (mon == 1) begin
          mlen = (yr % 4 == 0) ? 29 : 28;
        end else if (mon == 3 || mon == 5 || mon == 8 || mon == 10) begin
          mlen = 30;
        end else begin
          mlen = 31;
        end
      end
      r.accepted     = 1'b1;
      r.status       = ect_pkg::ST_OK;
      r.hour         = 5'(tod / 3600);
      r.minute       = 6'((tod / 60) % 60);
      r.second       = 6'(tod % 60);
      // day 0 of 1970 was a Thursday; Monday is 1
      r.weekday      = 3'((days + 3) % 7 + 1);
      r.month        = 4'(mon + 1);
      r.day_of_month = 5'(doy + 1);
      r.year_offset  = 7'(yr);
    end
    return r;
  endfunction

  function string fields(cal_word_t c);
    return $sformatf("acc %0d st %0d %0d:%0d:%0d wd %0d m %0d d %0d y %0d",
                     c.accepted, c.status, c.hour, c.minute, c.second,
                     c.weekday, c.month, c.day_of_month, c.year_offset);
  endfunction

  function void flag(string msg);
    n_errors++;
    if (n_errors <= 10) begin
      $display("ERROR %0d: %s", n_errors, msg);
    end
  endfunction

  // Accepted input word: queue its predicted result
  function void note_epoch(logic [31:0] t);
    cal_due_t e;
    e.epoch = t;
    e.cal   = calendar_of(t);
    cal_due.push_back(e);
  endfunction

  // Accepted output word: compare with oldest prediction
  function void check_calendar(cal_word_t got);
    cal_due_t e;
    n_checked++;
    if (cal_due.size() == 0) begin
      flag({"result with nothing pending: ", fields(got)});
    end else begin
      e = cal_due.pop_front();
      case (e.cal.status)
        ect_pkg::ST_OK:        n_converted++;
        ect_pkg::ST_NOT_READY: n_not_ready++;
        default:               n_range++;
      endcase
      if (got !== e.cal) begin
        flag($sformatf("epoch %0d want [%s] got [%s]", e.epoch,
                       fields(e.cal), fields(got)));
      end
    end
  endfunction
endclass

module tb;

  localparam int          PIPE_DEPTH = 8;
  localparam int          IDLE_LIMIT = 3000;
  localparam logic [31:0] DAY_SEC    = 32'd86400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_epoch_seconds = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_accepted;
  logic [1:0]  out_status;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;
  logic [2:0]  out_weekday;
  logic [3:0]  out_month;
  logic [4:0]  out_day_of_month;
  logic [6:0]  out_year_offset;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;

  calendar_scoreboard sb;
  bit          steady = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned cfg_writes = 0;

  epoch_to_calendar_gated u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_epoch_seconds (in_epoch_seconds),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_accepted     (out_accepted),
    .out_status       (out_status),
    .out_hour         (out_hour),
    .out_minute       (out_minute),
    .out_second       (out_second),
    .out_weekday      (out_weekday),
    .out_month        (out_month),
    .out_day_of_month (out_day_of_month),
    .out_year_offset  (out_year_offset),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver back-pressure, off during the steady stretch
  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 30);
  end

  // Handshake monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_epoch(in_epoch_seconds);
      end
      if (out_valid && !out_stall) begin
        sb.check_calendar('{out_accepted, ect_pkg::status_t'(out_status), out_hour,
                            out_minute, out_second, out_weekday, out_month,
                            out_day_of_month, out_year_offset});
      end
    end
  end

  // Watchdog: cycles without any word moving
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no traffic for %0d cycles", IDLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // One input word, with an optional gap ahead of it
  task automatic send_word(input logic [31:0] t);
    if (!steady && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_epoch_seconds <= t;
    do @(posedge clk); while (in_stall);
  endtask

  // Write the clock-ready register (only while the pipe is empty)
  task automatic write_ready(input logic v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.rtc_up = v;
    cfg_writes++;
  endtask

  // Stop sending, wait for every pending result, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.cal_due.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  // Range edges, leap days, year turnover, a run of weekdays
  task automatic send_corners();
    logic [31:0] pts [23];
    pts = '{32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
            ect_pkg::FIRST_SEC - 32'd1, ect_pkg::FIRST_SEC,
            ect_pkg::END_SEC - 32'd1, ect_pkg::END_SEC,
            ect_pkg::FIRST_SEC + 32'd59 * DAY_SEC - 32'd1,     // 2000-02-28 23:59:59
            ect_pkg::FIRST_SEC + 32'd59 * DAY_SEC,             // 2000-02-29
            ect_pkg::FIRST_SEC + 32'd60 * DAY_SEC,             // 2000-03-01
            ect_pkg::FIRST_SEC + 32'd366 * DAY_SEC - 32'd1,    // 2000-12-31 23:59:59
            ect_pkg::FIRST_SEC + 32'd366 * DAY_SEC,            // 2001-01-01
            ect_pkg::FIRST_SEC + 32'd425 * DAY_SEC,            // 2001-03-01, no leap day
            ect_pkg::FIRST_SEC + 32'd1520 * DAY_SEC,           // 2004-02-29
            ect_pkg::FIRST_SEC + 32'd35123 * DAY_SEC,          // 2096-02-29
            ect_pkg::FIRST_SEC + 32'd1000 * DAY_SEC + 32'd45296,
            ect_pkg::FIRST_SEC + 32'd1 * DAY_SEC + 32'd3661,
            ect_pkg::FIRST_SEC + 32'd2 * DAY_SEC + 32'd7322,
            ect_pkg::FIRST_SEC + 32'd3 * DAY_SEC + 32'd10983,
            ect_pkg::FIRST_SEC + 32'd4 * DAY_SEC + 32'd14644,
            ect_pkg::FIRST_SEC + 32'd5 * DAY_SEC + 32'd18305,
            ect_pkg::FIRST_SEC + 32'd6 * DAY_SEC + 32'd86399};
    foreach (pts[i]) begin
      send_word(pts[i]);
    end
  endtask

  // Random words: mostly inside the window, some at day and year edges,
  // the rest over the full 32-bit range
  task automatic send_random(input int n);
    int unsigned mode;
    int unsigned d;
    int unsigned y;
    logic [31:0] t;
    for (int i = 0; i < n; i++) begin
      mode = $urandom_range(99);
      if (mode < 55) begin
        t = $urandom_range(ect_pkg::END_SEC - 32'd1, ect_pkg::FIRST_SEC);
      end else if (mode < 70) begin
        d = $urandom_range(36525, 0);
        t = ect_pkg::FIRST_SEC + 32'(d) * DAY_SEC + 32'($urandom_range(2)) - 32'd1;
      end else if (mode < 80) begin
        y = $urandom_range(100, 0);
        d = y * 365 + (y + 3) / 4;
        t = ect_pkg::FIRST_SEC + 32'(d) * DAY_SEC + 32'($urandom_range(2)) - 32'd1;
      end else begin
        t = $urandom();
      end
      send_word(t);
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Register still at its reset value: everything rejected
    send_corners();
    send_random(40);
    drain();

    write_ready(1'b1);
    send_corners();
    send_random(420);
    steady = 1'b1;
    send_random(150);
    steady = 1'b0;
    drain();

    write_ready(1'b0);
    send_random(30);
    drain();

    write_ready(1'b1);
    send_random(110);
    drain();

    $display("Checked %0d results: %0d converted, %0d clock not ready, %0d out of range",
             sb.n_checked, sb.n_converted, sb.n_not_ready, sb.n_range);
    $display("Register writes: %0d, errors: %0d", cfg_writes, sb.n_errors);
    if (sb.n_errors == 0 && sb.cal_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/ect_pkg.sv
hdl/ect_day_split.sv
hdl/ect_tod.sv
hdl/ect_date.sv
hdl/epoch_to_calendar_gated.sv
tb/tb.sv
